>>> rtl/pwmt_pkg.sv
// shared types and constants for the four-channel pwm timer
// no dependencies
`default_nettype none

package pwmt_pkg;

	localparam int CMD_BITS     = 3;
	localparam int CHANNEL_BITS = 2;
	localparam int VALUE_BITS   = 17;
	localparam int FIELD_BITS   = 16;
	localparam int ENABLE_BITS  = 4;
	localparam int CFG_IDX_BITS = 2;
	localparam int PWM_BITS     = 4;

	localparam logic [FIELD_BITS-1:0] PERIOD_RESET = 16'hFFFF;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_TICK         = 3'd0,
		CMD_SET_COMPARE  = 3'd1,
		CMD_START        = 3'd2,
		CMD_STOP         = 3'd3,
		CMD_FORCE_UPDATE = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PRESCALER      = 2'd0,
		REG_PERIOD         = 2'd1,
		REG_CHANNEL_ENABLE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CMD_BITS-1:0]     command;
		logic [CHANNEL_BITS-1:0] channel;
		logic [VALUE_BITS-1:0]   value;
	} item_t;

endpackage

`default_nettype wire

>>> rtl/four_channel_pwm_timer.sv
// top level of the four-channel edge-aligned pwm timer with prescaler
// depends on pwmt_pkg, pwmt_in_stage and pwmt_core
`default_nettype none

// Each input item (tick, set compare, start, stop, force update) produces
// exactly one result carrying the channel levels, the main counter and the
// update flag as they stand after that item. The block takes one item per
// clock cycle unless stalled; a result passes through the input register
// and then through the counter and compare logic into the result register.
// Results leave in order and stall the input only when both registers are
// full and the result is not taken. Set compare writes the buffered
// compare; the active compares follow at a counter overflow or a force
// update. Configuration writes (prescaler, period, channel enable) take
// effect at once and are meant for when no transfer is in flight.
module four_channel_pwm_timer #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNTER_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pwmt_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [pwmt_pkg::FIELD_BITS-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [pwmt_pkg::CMD_BITS-1:0]     command,
	input  wire logic [pwmt_pkg::CHANNEL_BITS-1:0] channel,
	input  wire logic [pwmt_pkg::VALUE_BITS-1:0]   value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [pwmt_pkg::PWM_BITS-1:0]          pwm_out,
	output logic [pwmt_pkg::FIELD_BITS-1:0]        count,
	output logic                                   update_event
);
	import pwmt_pkg::*;

	item_t item;
	item_t item_s1;
	logic  valid_s1;
	logic  take;

	assign item.command = command;
	assign item.channel = channel;
	assign item.value   = value;

	pwmt_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pwmt_core #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.take         (take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pwm_out      (pwm_out),
		.count        (count),
		.update_event (update_event)
	);

endmodule

`default_nettype wire

>>> rtl/pwmt_in_stage.sv
// input register of the pwm timer: holds one accepted command item
// depends on pwmt_pkg
`default_nettype none

module pwmt_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire pwmt_pkg::item_t item,
	input  wire logic           take,
	output logic                valid_s1,
	output pwmt_pkg::item_t     item_s1
);
	import pwmt_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pwmt_core.sv
// timer state, configuration registers, per-item update and result register
// depends on pwmt_pkg
`default_nettype none

module pwmt_core #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNTER_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pwmt_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [pwmt_pkg::FIELD_BITS-1:0]   cfg_data,
	input  wire logic                              valid_s1,
	input  wire pwmt_pkg::item_t                   item_s1,
	output logic                                   take,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [pwmt_pkg::PWM_BITS-1:0]          pwm_out,
	output logic [pwmt_pkg::FIELD_BITS-1:0]        count,
	output logic                                   update_event
);
	import pwmt_pkg::*;

	localparam int CW = (COUNTER_BITS > VALUE_BITS) ? COUNTER_BITS : VALUE_BITS;

	logic [FIELD_BITS-1:0]   prescaler_q;
	logic [FIELD_BITS-1:0]   period_q;
	logic [ENABLE_BITS-1:0]  enable_q;

	logic [FIELD_BITS-1:0]   psc_q, psc_d;
	logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
	logic [VALUE_BITS-1:0]   buf_q [NUM_CHANNELS];
	logic [VALUE_BITS-1:0]   buf_d [NUM_CHANNELS];
	logic [VALUE_BITS-1:0]   act_q [NUM_CHANNELS];
	logic [VALUE_BITS-1:0]   act_d [NUM_CHANNELS];
	logic                    run_q, run_d;
	logic                    evt_d;
	logic                    load;
	logic [PWM_BITS-1:0]     pwm_d;
	logic                    fire;

	assign take = !out_valid || out_ready;
	assign fire = valid_s1 && take;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
			period_q    <= PERIOD_RESET;
			enable_q    <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_PRESCALER:      prescaler_q <= cfg_data;
				REG_PERIOD:         period_q    <= cfg_data;
				REG_CHANNEL_ENABLE: enable_q    <= cfg_data[ENABLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// next state for one item
	always_comb begin
		psc_d = psc_q;
		cnt_d = cnt_q;
		run_d = run_q;
		evt_d = 1'b0;
		load  = 1'b0;
		buf_d = buf_q;
		case (cmd_t'(item_s1.command))
			CMD_TICK: begin
				if (run_q) begin
					if (psc_q >= prescaler_q) begin
						psc_d = '0;
						if (CW'(cnt_q) >= CW'(period_q)) begin
							cnt_d = '0;
							load  = 1'b1;
							evt_d = 1'b1;
						end else begin
							cnt_d = cnt_q + COUNTER_BITS'(1);
						end
					end else begin
						psc_d = psc_q + FIELD_BITS'(1);
					end
				end
			end
			CMD_SET_COMPARE: begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (item_s1.channel == CHANNEL_BITS'(c)) begin
						buf_d[c] = item_s1.value;
					end
				end
			end
			CMD_START: run_d = 1'b1;
			CMD_STOP:  run_d = 1'b0;
			CMD_FORCE_UPDATE: begin
				psc_d = '0;
				cnt_d = '0;
				load  = 1'b1;
				evt_d = 1'b1;
			end
			default: ;
		endcase
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			act_d[c] = load ? buf_q[c] : act_q[c];
		end
	end

	// channel compares on the updated state
	for (genvar c = 0; c < PWM_BITS; c++) begin : g_pwm
		if (c < NUM_CHANNELS) begin : g_on
			assign pwm_d[c] = enable_q[c] && (CW'(cnt_d) < CW'(act_d[c]));
		end else begin : g_off
			assign pwm_d[c] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psc_q <= '0;
			cnt_q <= '0;
			run_q <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				buf_q[c] <= '0;
				act_q[c] <= '0;
			end
		end else if (fire) begin
			psc_q <= psc_d;
			cnt_q <= cnt_d;
			run_q <= run_d;
			buf_q <= buf_d;
			act_q <= act_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pwm_out      <= pwm_d;
			count        <= FIELD_BITS'(cnt_d);
			update_event <= evt_d;
		end
	end

endmodule

`default_nettype wire
